[rtl/core/multi_slot_stopwatch_defines.svh]
// assertion macros shared by the stopwatch checker
`ifndef MULTI_SLOT_STOPWATCH_DEFINES_SVH
`define MULTI_SLOT_STOPWATCH_DEFINES_SVH

// clocked assertion, muted while reset is asserted
`define MSS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MSS_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mss_pkg.sv]
// types and constants for the multi-slot stopwatch
`timescale 1ns / 1ps
`default_nettype none

package mss_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	// claim free only looks at indices the 4-bit slot field can name
	localparam int FREE_LIMIT = (SLOTS < 16) ? SLOTS : 16;

	localparam logic [3:0] OP_TICK       = 4'd0;
	localparam logic [3:0] OP_START      = 4'd1;
	localparam logic [3:0] OP_STOP       = 4'd2;
	localparam logic [3:0] OP_RESTART    = 4'd3;
	localparam logic [3:0] OP_CLAIM      = 4'd4;
	localparam logic [3:0] OP_CLAIM_FREE = 4'd5;
	localparam logic [3:0] OP_RELEASE    = 4'd6;
	localparam logic [3:0] OP_RESTAMP    = 4'd7;
	localparam logic [3:0] OP_QUERY      = 4'd8;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_NO_FREE = 1'b1;

	typedef struct packed {
		logic [3:0] opcode;
		logic [3:0] slot;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  slot_out;
		logic        status;
		logic        slot_busy;
		logic [31:0] delta_ms;
		logic [10:0] hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
		logic [9:0]  millis;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/core/multi_slot_stopwatch.sv]
// multi-slot stopwatch: millisecond counter, slot table and time breakdown pipeline
`timescale 1ns / 1ps
`default_nettype none

// One command enters per cycle when nothing stalls, and its single response leaves stage 6.
// All counter and slot-table updates happen in stage 1, so commands
// take effect strictly in order; the start-stamp memory is read as the command is
// taken, with a bypass from the write of the command ahead of it. Stages 2 to 6 split
// the elapsed time into hours, minutes, seconds and milliseconds with three reciprocal
// multiplies, one in each of stages 2 to 4. The stages close up bubbles, so commands
// keep flowing until the stages fill while a response waits. Busy flags clear at reset;
// the stamp memory holds no reset value.
module multi_slot_stopwatch (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_stall,
	input  wire mss_pkg::cmd_t  cmd,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output mss_pkg::rsp_t       rsp
);
	import mss_pkg::*;

	localparam logic [28:0] INV_1000   = 29'd274877907; // 2^38 / 1000, rounded up
	localparam logic [23:0] INV_60_MIN = 24'd8947849;   // 2^29 / 60, rounded up
	localparam logic [17:0] INV_60_HR  = 18'd139811;    // 2^23 / 60, rounded up

	typedef struct packed {
		logic [3:0]  slot_out;
		logic        status;
		logic        slot_busy;
		logic [31:0] delta_ms;
	} head_t;

	// pipeline control
	logic [6:1] vld_q;
	logic [6:1] adv;
	logic       leave1;

	always_comb begin
		adv[6] = !vld_q[6] || !rsp_stall;
		for (int k = 5; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k + 1];
		end
	end

	assign cmd_stall = !adv[1];
	assign leave1    = vld_q[1] && adv[2];
	assign rsp_valid = vld_q[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= cmd_valid;
			end
			for (int k = 2; k <= 6; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	// stage 1: command register, state and stamp memory
	cmd_t             cmd_s1;
	logic [31:0]      stamp_s1;
	logic [31:0]      elapsed_q, elapsed_d;
	logic             running_q, running_d;
	logic [SLOTS-1:0] busy_q, busy_d;
	logic [31:0]      stamp_mem [SLOTS];

	logic             in_range;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] rd_idx;
	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic             mem_we;
	head_t            head_d;

	assign in_range = int'(cmd_s1.slot) < SLOTS;
	assign idx_s1   = IDX_W'(cmd_s1.slot);
	assign rd_idx   = IDX_W'(cmd.slot);
	assign mem_we   = leave1 && wr_en;

	// lowest idle slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = FREE_LIMIT - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		elapsed_d = elapsed_q;
		running_d = running_q;
		busy_d    = busy_q;
		wr_en     = 1'b0;
		wr_idx    = idx_s1;
		head_d    = '0;
		case (cmd_s1.opcode)
			OP_TICK: begin
				if (running_q) begin
					elapsed_d = elapsed_q + 32'd1;
				end
			end
			OP_START: begin
				elapsed_d = '0;
				running_d = 1'b1;
			end
			OP_STOP: begin
				elapsed_d = '0;
				running_d = 1'b0;
			end
			OP_RESTART: begin
				if (elapsed_q == '0) begin
					running_d = 1'b1;
				end
			end
			OP_CLAIM: begin
				head_d.slot_out = cmd_s1.slot;
				if (in_range) begin
					busy_d[idx_s1]   = 1'b1;
					wr_en            = 1'b1;
					head_d.slot_busy = 1'b1;
				end
			end
			OP_CLAIM_FREE: begin
				if (free_found) begin
					busy_d[free_idx] = 1'b1;
					wr_en            = 1'b1;
					wr_idx           = free_idx;
					head_d.slot_out  = 4'(free_idx);
					head_d.slot_busy = 1'b1;
				end else begin
					head_d.status = STATUS_NO_FREE;
				end
			end
			OP_RELEASE: begin
				head_d.slot_out = cmd_s1.slot;
				if (in_range) begin
					busy_d[idx_s1] = 1'b0;
					wr_en          = 1'b1;
				end
			end
			OP_RESTAMP: begin
				head_d.slot_out = cmd_s1.slot;
				if (in_range) begin
					wr_en            = 1'b1;
					head_d.slot_busy = busy_q[idx_s1];
				end
			end
			OP_QUERY: begin
				head_d.slot_out = cmd_s1.slot;
				if (in_range && busy_q[idx_s1]) begin
					head_d.slot_busy = 1'b1;
					head_d.delta_ms  = elapsed_q - stamp_s1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			running_q <= 1'b0;
			busy_q    <= '0;
		end else if (leave1) begin
			elapsed_q <= elapsed_d;
			running_q <= running_d;
			busy_q    <= busy_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stamp_mem[wr_idx] <= elapsed_q;
		end
	end

	// read as the command is taken; forward the stamp being written this cycle
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			cmd_s1 <= cmd;
			if (mem_we && (wr_idx == rd_idx)) begin
				stamp_s1 <= elapsed_q;
			end else begin
				stamp_s1 <= stamp_mem[rd_idx];
			end
		end
	end

	// stages 2 to 6: time breakdown
	head_t       head_s2, head_s3, head_s4, head_s5;
	logic [22:0] q1_s3, q1_s4;
	logic [9:0]  millis_s4, millis_s5;
	logic [16:0] q2_s4, q2_s5;
	logic [5:0]  seconds_s5;
	logic [10:0] hours_s5;
	rsp_t        rsp_s6;

	logic [60:0] prod_sec;
	logic [46:0] prod_min;
	logic [34:0] prod_hr;
	logic [31:0] ms_rem;
	logic [22:0] sec_rem;
	logic [16:0] min_rem;

	assign prod_sec = 61'(head_s2.delta_ms) * 61'(INV_1000);
	assign ms_rem   = head_s3.delta_ms - (32'(q1_s3) * 32'd1000);
	assign prod_min = 47'(q1_s3) * 47'(INV_60_MIN);
	assign sec_rem  = q1_s4 - (23'(q2_s4) * 23'd60);
	assign prod_hr  = 35'(q2_s4) * 35'(INV_60_HR);
	assign min_rem  = q2_s5 - (17'(hours_s5) * 17'd60);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			head_s2 <= head_d;
		end
		if (adv[3]) begin
			head_s3 <= head_s2;
			q1_s3   <= prod_sec[60:38];
		end
		if (adv[4]) begin
			head_s4   <= head_s3;
			q1_s4     <= q1_s3;
			millis_s4 <= ms_rem[9:0];
			q2_s4     <= prod_min[45:29];
		end
		if (adv[5]) begin
			head_s5    <= head_s4;
			millis_s5  <= millis_s4;
			q2_s5      <= q2_s4;
			seconds_s5 <= sec_rem[5:0];
			hours_s5   <= prod_hr[33:23];
		end
		if (adv[6]) begin
			rsp_s6.slot_out  <= head_s5.slot_out;
			rsp_s6.status    <= head_s5.status;
			rsp_s6.slot_busy <= head_s5.slot_busy;
			rsp_s6.delta_ms  <= head_s5.delta_ms;
			rsp_s6.hours     <= hours_s5;
			rsp_s6.minutes   <= min_rem[5:0];
			rsp_s6.seconds   <= seconds_s5;
			rsp_s6.millis    <= millis_s5;
		end
	end

	assign rsp = rsp_s6;

endmodule

`default_nettype wire

[rtl/core/mss_checker.sv]
// port-level checks for the multi-slot stopwatch, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "multi_slot_stopwatch_defines.svh"

module mss_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                rsp_valid,
	input wire                rsp_stall,
	input wire mss_pkg::rsp_t rsp
);
	import mss_pkg::*;

	// a held response keeps its fields
	`MSS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "response changed while stalled")

	// reset empties the pipeline by the following edge
	`MSS_ASSERT_RST(a_rst_quiet, !arst_n |=> !rsp_valid, "response valid during reset")

	// breakdown must add back up to the elapsed time
	`MSS_ASSERT(a_breakdown, rsp_valid |-> rsp.millis < 10'd1000 && rsp.seconds < 6'd60 && rsp.minutes < 6'd60 && (32'(rsp.hours) * 32'd3600000 + 32'(rsp.minutes) * 32'd60000 + 32'(rsp.seconds) * 32'd1000 + 32'(rsp.millis)) == rsp.delta_ms, "time breakdown inconsistent")

	// failed free-slot search reports nothing else
	`MSS_ASSERT(a_no_free, rsp_valid && rsp.status == STATUS_NO_FREE |-> rsp.slot_out == 4'd0 && !rsp.slot_busy && rsp.delta_ms == 32'd0, "no-free status with slot data")

endmodule

bind multi_slot_stopwatch mss_checker u_mss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

[dv/tb_top.sv]
// self-checking testbench for the multi-slot stopwatch
`timescale 1ns / 1ps

module tb_top;
	import mss_pkg::*;

	localparam logic [31:0] MS_PER_SEC  = 32'd1000;
	localparam logic [31:0] SEC_PER_MIN = 32'd60;
	localparam logic [31:0] MS_PER_MIN  = MS_PER_SEC * SEC_PER_MIN;
	localparam logic [31:0] MS_PER_HOUR = MS_PER_MIN * SEC_PER_MIN;
	localparam logic [3:0]  OP_UNDEF_LO = OP_QUERY + 4'd1;
	localparam logic [3:0]  OP_UNDEF_HI = 4'hF;
	localparam logic [3:0]  SLOT_MAX    = 4'hF;
	localparam int          CHUNK_ITEMS = 250;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	multi_slot_stopwatch uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// predicted stopwatch state
	logic [31:0] ms_count;
	logic        is_running;
	logic        slot_taken [SLOTS];
	logic [31:0] slot_stamp [SLOTS];

	cmd_t cmd_backlog [$];
	rsp_t watch_answers [$];
	rsp_t answer;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stage = 0;
	logic hold_rsp = 1'b0;
	int n_added = 0;
	int n_taken = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_timed = 0;
	int n_wrapped = 0;
	int n_full = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic step_watch(input cmd_t c, output rsp_t r);
		logic [31:0] d;
		int found;
		bit in_range;
		r = '0;
		in_range = int'(c.slot) < SLOTS;
		case (c.opcode)
			OP_TICK: begin
				if (is_running)
					ms_count = ms_count + 32'd1;
			end
			OP_START: begin
				ms_count = '0;
				is_running = 1'b1;
			end
			OP_STOP: begin
				ms_count = '0;
				is_running = 1'b0;
			end
			OP_RESTART: begin
				if (ms_count == '0)
					is_running = 1'b1;
			end
			OP_CLAIM: begin
				r.slot_out = c.slot;
				if (in_range) begin
					slot_taken[c.slot] = 1'b1;
					slot_stamp[c.slot] = ms_count;
					r.slot_busy = 1'b1;
				end
			end
			OP_CLAIM_FREE: begin
				found = -1;
				for (int i = 0; i < FREE_LIMIT; i++)
					if (found < 0 && !slot_taken[i])
						found = i;
				if (found >= 0) begin
					slot_taken[found] = 1'b1;
					slot_stamp[found] = ms_count;
					r.slot_out = found[3:0];
					r.slot_busy = 1'b1;
				end else begin
					r.status = STATUS_NO_FREE;
					n_full++;
				end
			end
			OP_RELEASE: begin
				r.slot_out = c.slot;
				if (in_range) begin
					slot_taken[c.slot] = 1'b0;
					slot_stamp[c.slot] = ms_count;
				end
			end
			OP_RESTAMP: begin
				r.slot_out = c.slot;
				if (in_range) begin
					slot_stamp[c.slot] = ms_count;
					r.slot_busy = slot_taken[c.slot];
				end
			end
			OP_QUERY: begin
				r.slot_out = c.slot;
				if (in_range && slot_taken[c.slot]) begin
					d = ms_count - slot_stamp[c.slot];
					r.slot_busy = 1'b1;
					r.delta_ms = d;
					r.hours = 11'(d / MS_PER_HOUR);
					r.minutes = 6'((d / MS_PER_MIN) % SEC_PER_MIN);
					r.seconds = 6'((d / MS_PER_SEC) % SEC_PER_MIN);
					r.millis = 10'(d % MS_PER_SEC);
					if (d != '0)
						n_timed++;
					if (d[31])
						n_wrapped++;
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	task automatic add_cmd(input logic [3:0] op, input logic [3:0] s);
		cmd_t c;
		c.opcode = op;
		c.slot = s;
		cmd_backlog.push_back(c);
		n_added++;
	endtask

	function automatic logic [3:0] any_slot();
		return 4'($urandom_range(SLOT_MAX));
	endfunction

	// mostly well-formed measurement sequences, with bursts that fill the table and some noise
	task automatic gen_traffic(input int count);
		int stop_at;
		int kind;
		int k;
		logic [3:0] s;
		stop_at = n_added + count;
		while (n_added < stop_at) begin
			kind = $urandom_range(99);
			if (kind < 30) begin
				k = $urandom_range(12, 1);
				repeat (k) add_cmd(OP_TICK, any_slot());
			end else if (kind < 45) begin
				s = any_slot();
				add_cmd(OP_CLAIM, s);
				k = $urandom_range(8);
				repeat (k) add_cmd(OP_TICK, any_slot());
				add_cmd(OP_QUERY, s);
				if ($urandom_range(1))
					add_cmd(OP_RELEASE, s);
			end else if (kind < 55) begin
				k = $urandom_range(18, 2);
				repeat (k) add_cmd(OP_CLAIM_FREE, any_slot());
				k = $urandom_range(4, 1);
				repeat (k) add_cmd(OP_RELEASE, any_slot());
			end else if (kind < 63) begin
				k = $urandom_range(9);
				if (k < 4)
					add_cmd(OP_START, any_slot());
				else if (k < 7)
					add_cmd(OP_RESTART, any_slot());
				else
					add_cmd(OP_STOP, any_slot());
			end else if (kind < 88) begin
				add_cmd(4'($urandom_range(OP_QUERY, OP_CLAIM)), any_slot());
			end else begin
				k = $urandom_range(3, 1);
				repeat (k) begin
					if ($urandom_range(1))
						add_cmd(4'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO)), any_slot());
					else
						add_cmd(4'($urandom_range(OP_UNDEF_HI)), any_slot());
				end
			end
		end
	endtask

	task automatic drain();
		while (cmd_backlog.size() != 0 || cmd_valid || watch_answers.size() != 0)
			@(negedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				step_watch(cmd, answer);
				watch_answers.push_back(answer);
				n_taken++;
			end
			if (!cmd_valid || !cmd_stall) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd_valid <= 1'b1;
					cmd <= cmd_backlog.pop_front();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (watch_answers.size() == 0) begin
					n_errors++;
					$display("%0t: transaction with no expected result, actual %h", $time, rsp);
				end else begin
					answer = watch_answers.pop_front();
					check_field("slot_out", answer.slot_out, rsp.slot_out);
					check_field("status", answer.status, rsp.status);
					check_field("slot_busy", answer.slot_busy, rsp.slot_busy);
					check_field("delta_ms", answer.delta_ms, rsp.delta_ms);
					check_field("hours", answer.hours, rsp.hours);
					check_field("minutes", answer.minutes, rsp.minutes);
					check_field("seconds", answer.seconds, rsp.seconds);
					check_field("millis", answer.millis, rsp.millis);
					n_checked++;
				end
			end
			rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
		end
	end

	// long receiver hold-off so the pipeline fills and backs up into the command side
	initial begin
		wait (stage == 3);
		repeat (10) @(posedge clk);
		hold_rsp <= 1'b1;
		repeat (150) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	initial begin
		ms_count = '0;
		is_running = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_taken[i] = 1'b0;
			slot_stamp[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 86;
		stage = 1;
		add_cmd(OP_QUERY, 4'd0);
		add_cmd(OP_START, 4'd0);
		repeat (3) add_cmd(OP_TICK, SLOT_MAX);
		add_cmd(OP_CLAIM, SLOT_MAX);
		add_cmd(OP_CLAIM_FREE, SLOT_MAX);
		add_cmd(OP_TICK, 4'd0);
		add_cmd(OP_QUERY, SLOT_MAX);
		// counter not at zero, so restart does nothing
		add_cmd(OP_RESTART, 4'd0);
		add_cmd(OP_STOP, 4'd0);
		// counter now below the stamp: wrapping difference near the top of the range
		add_cmd(OP_QUERY, 4'd0);
		add_cmd(OP_TICK, 4'd0);
		add_cmd(OP_RESTART, 4'd0);
		add_cmd(OP_TICK, 4'd0);
		add_cmd(OP_RESTAMP, 4'd0);
		add_cmd(OP_RESTAMP, 4'd7);
		add_cmd(OP_RELEASE, SLOT_MAX);
		add_cmd(OP_QUERY, SLOT_MAX);
		add_cmd(OP_UNDEF_HI, SLOT_MAX);
		add_cmd(OP_UNDEF_LO, 4'd0);
		add_cmd(OP_QUERY, 4'd0);
		drain();

		gen_traffic(CHUNK_ITEMS);
		drain();

		send_idle_pct = 86;
		recv_idle_pct = 26;
		stage = 2;
		gen_traffic(CHUNK_ITEMS);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		stage = 3;
		gen_traffic(CHUNK_ITEMS);
		drain();
		repeat (20) @(posedge clk);

		$display("%0d commands checked: %0d timed queries (%0d wrapped), %0d full-table claims",
			n_checked, n_timed, n_wrapped, n_full);
		if (n_errors == 0 && watch_answers.size() == 0 && n_checked == n_taken)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
